/* rtl/scm_pkg.sv */
// Shared types and codes for the sensor channel monitor.
package scm_pkg;

  // Input operation codes.
  typedef enum logic [1:0] {
    OP_RECORD  = 2'd0,
    OP_OFFLINE = 2'd1,
    OP_ACK     = 2'd2,
    OP_HISTORY = 2'd3
  } op_t;

  // Result kind codes.
  typedef enum logic [2:0] {
    KIND_ECHO      = 3'd0,
    KIND_EXCURSION = 3'd1,
    KIND_OFFLINE   = 3'd2,
    KIND_ACK       = 3'd3,
    KIND_HIST      = 3'd4,
    KIND_EMPTY     = 3'd5
  } kind_t;

  // Configuration register indexes.
  localparam logic [1:0] CFG_THRESHOLD = 2'd0;
  localparam logic [1:0] CFG_METRIC    = 2'd1;

  localparam logic signed [31:0] THRESHOLD_RESET = 32'sd5500;
  localparam int                 AVG_SHIFT       = 2;

  // One accepted transaction as it travels through the queue.
  typedef struct packed {
    op_t         op;
    logic [3:0]  session;
    logic [1:0]  metric;
    logic [31:0] value;
    logic [31:0] timestamp;
    logic [31:0] now;
  } cmd_t;

endpackage

/* rtl/scm_front.sv */
// Front end: accepts transactions, drops out-of-range ones, and queues the rest.
module scm_front #(
  parameter int SESSIONS = 16,
  parameter int METRICS  = 4,
  parameter int QDEPTH   = 2
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  output logic          busy,
  input  scm_pkg::cmd_t in_cmd,
  output logic          q_valid,
  output scm_pkg::cmd_t q_cmd,
  input  logic          q_pop
);
  import scm_pkg::*;

  localparam int QW = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;

  cmd_t          mem_r [QDEPTH];
  logic [QW-1:0] wp_r, rp_r;
  logic [QW:0]   cnt_r, cnt_nxt;
  logic          accept, keep;

  assign busy    = (cnt_r == (QW+1)'(QDEPTH));
  assign accept  = start && !busy;
  // Out-of-range session, or out-of-range metric for channel operations.
  assign keep    = ({24'd0, in_cmd.session} < 28'(SESSIONS)) &&
                   (in_cmd.op == OP_OFFLINE || in_cmd.op == OP_ACK ||
                    ({30'd0, in_cmd.metric} < 32'(METRICS)));
  assign q_valid = (cnt_r != '0);
  assign q_cmd   = mem_r[rp_r];

  always_comb begin
    cnt_nxt = cnt_r;
    if (accept && keep) cnt_nxt = cnt_nxt + 1'b1;
    if (q_pop) cnt_nxt = cnt_nxt - 1'b1;
  end

  // Queue pointers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (accept && keep) wp_r <= (wp_r == QW'(QDEPTH-1)) ? '0 : wp_r + 1'b1;
      if (q_pop) rp_r <= (rp_r == QW'(QDEPTH-1)) ? '0 : rp_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && keep) mem_r[wp_r] <= in_cmd;
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= (QW+1)'(QDEPTH)) else $error("queue overflow");
  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> q_valid) else $error("pop on empty queue");
  a_full_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r == (QW+1)'(QDEPTH)) |-> busy) else $error("full but not busy");
endmodule

/* rtl/scm_back.sv */
// Back end: executes queued transactions against channel state and emits results.
module scm_back #(
  parameter int SESSIONS      = 16,
  parameter int METRICS       = 4,
  parameter int HISTORY_DEPTH = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                q_valid,
  input  scm_pkg::cmd_t       q_cmd,
  output logic                q_pop,
  input  logic signed [31:0]  threshold,
  input  logic [1:0]          alert_metric,
  output logic                out_valid,
  output logic [2:0]          out_kind,
  output logic [3:0]          out_session,
  output logic [1:0]          out_metric,
  output logic signed [31:0]  out_value,
  output logic [31:0]         out_timestamp,
  output logic                out_offline_seen,
  output logic [31:0]         out_offline_elapsed_ms,
  output logic                out_excursion_seen,
  output logic [31:0]         out_excursion_elapsed_ms,
  output logic                out_excursion_kept,
  output logic                out_last
);
  import scm_pkg::*;

  localparam int SW  = (SESSIONS > 1) ? $clog2(SESSIONS) : 1;
  localparam int MW  = (METRICS > 1) ? $clog2(METRICS) : 1;
  localparam int NCH = SESSIONS * METRICS;
  localparam int CW  = (NCH > 1) ? $clog2(NCH) : 1;
  localparam int HW  = $clog2(HISTORY_DEPTH);
  localparam int FW  = $clog2(HISTORY_DEPTH + 1);

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_EXEC = 4'b0010,
    ST_ALRM = 4'b0100,
    ST_HIST = 4'b1000
  } state_t;

  state_t state_r, state_nxt;
  cmd_t   cmd_r;

  // Channel memories; ring is addressed {channel, slot}.
  logic [63:0]        ring_mem [NCH*(1<<HW)];
  logic signed [31:0] avg_mem  [NCH];
  logic [63:0]        ring_rd_r;
  logic signed [31:0] avg_rd_r, chk_avg_r;

  // Per-channel and per-session control flops.
  logic [HW-1:0] wslot_r [NCH];
  logic [FW-1:0] fill_r  [NCH];
  logic [NCH-1:0] avalid_r;
  logic [SESSIONS-1:0] exc_r, off_r;
  logic [31:0] exc_time_r [SESSIONS];
  logic [31:0] off_time_r [SESSIONS];

  // Channel control words read out for the transaction being popped.
  logic [HW-1:0] wslot_rd_r;
  logic [FW-1:0] fill_rd_r;
  logic          avalid_rd_r, chk_valid_r;

  logic [HW-1:0] hidx_r;
  logic [FW-1:0] hleft_r;
  logic          hpend_r;
  logic signed [31:0] new_avg_r;

  logic [SW-1:0] sess;
  logic [CW-1:0] ch, q_ch, q_ach;
  logic          am_ok;
  logic signed [32:0] diff;
  logic signed [31:0] new_avg;
  logic [FW-1:0] fill_now;
  logic [HW-1:0] hstart;

  assign sess  = cmd_r.session[SW-1:0];
  assign ch    = CW'({24'd0, cmd_r.session} * METRICS + {30'd0, cmd_r.metric});
  assign q_ch  = CW'({24'd0, q_cmd.session} * METRICS + {30'd0, q_cmd.metric});
  assign q_ach = CW'({24'd0, q_cmd.session} * METRICS + {30'd0, alert_metric});
  assign am_ok = ({30'd0, alert_metric} < 32'(METRICS));
  assign diff  = {cmd_r.value[31], cmd_r.value} - {avg_rd_r[31], avg_rd_r};
  assign new_avg = avalid_rd_r ? 32'(avg_rd_r + 32'(diff >>> AVG_SHIFT))
                               : $signed(cmd_r.value);
  assign fill_now = fill_rd_r;
  assign hstart = (fill_now == FW'(HISTORY_DEPTH)) ? wslot_rd_r : '0;

  assign q_pop = (state_r == ST_IDLE) && q_valid;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: if (q_valid) state_nxt = ST_EXEC;
      ST_EXEC: begin
        state_nxt = ST_IDLE;
        if (cmd_r.op == OP_RECORD && MW > 0 &&
            cmd_r.metric == alert_metric && new_avg > threshold && !exc_r[sess])
          state_nxt = ST_ALRM;
        if (cmd_r.op == OP_HISTORY && fill_now != '0) state_nxt = ST_HIST;
      end
      ST_ALRM: state_nxt = ST_IDLE;
      ST_HIST: if (hpend_r && hleft_r == '0) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Memory reads: average in IDLE for the popped command, ring during history.
  always_ff @(posedge clk) begin
    avg_rd_r  <= avg_mem[q_ch];
    chk_avg_r <= avg_mem[q_ach];
    ring_rd_r <= ring_mem[{ch, hidx_r}];
    if (state_r == ST_EXEC && cmd_r.op == OP_RECORD) begin
      avg_mem[ch] <= new_avg;
      ring_mem[{ch, wslot_rd_r}] <= {cmd_r.timestamp, cmd_r.value};
    end
  end

  // Channel control reads, taken alongside the average read.
  always_ff @(posedge clk) begin
    wslot_rd_r  <= wslot_r[q_ch];
    fill_rd_r   <= fill_r[q_ch];
    avalid_rd_r <= avalid_r[q_ch];
    chk_valid_r <= avalid_r[q_ach];
  end

  // Control state and results.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      avalid_r  <= '0;
      exc_r     <= '0;
      off_r     <= '0;
      out_valid <= 1'b0;
      hpend_r   <= 1'b0;
      for (int i = 0; i < NCH; i++) begin
        wslot_r[i] <= '0;
        fill_r[i]  <= '0;
      end
    end else begin
      state_r   <= state_nxt;
      out_valid <= 1'b0;
      if (q_pop) cmd_r <= q_cmd;
      if (state_r == ST_EXEC) begin
        out_valid <= !(cmd_r.op == OP_OFFLINE && off_r[sess]) &&
                     !(cmd_r.op == OP_HISTORY && fill_now != '0);
        out_kind <= KIND_ECHO;
        out_session <= cmd_r.session;
        out_metric <= cmd_r.metric;
        out_value <= '0;
        out_timestamp <= '0;
        out_offline_seen <= 1'b0;
        out_offline_elapsed_ms <= '0;
        out_excursion_seen <= 1'b0;
        out_excursion_elapsed_ms <= '0;
        out_excursion_kept <= 1'b0;
        out_last <= 1'b1;
        case (cmd_r.op)
          OP_RECORD: begin
            out_value <= $signed(cmd_r.value);
            out_timestamp <= cmd_r.timestamp;
            out_last <= (state_nxt != ST_ALRM);
            new_avg_r <= new_avg;
            avalid_r[ch] <= 1'b1;
            wslot_r[ch] <= (wslot_rd_r == HW'(HISTORY_DEPTH-1)) ? '0 : wslot_rd_r + 1'b1;
            if (fill_now != FW'(HISTORY_DEPTH)) fill_r[ch] <= fill_now + 1'b1;
            if (state_nxt == ST_ALRM) begin
              exc_r[sess] <= 1'b1;
              exc_time_r[sess] <= cmd_r.now;
            end
          end
          OP_OFFLINE: begin
            out_kind <= KIND_OFFLINE;
            out_metric <= '0;
            out_timestamp <= cmd_r.timestamp;
            if (!off_r[sess]) begin
              off_r[sess] <= 1'b1;
              off_time_r[sess] <= cmd_r.now;
            end
          end
          OP_ACK: begin
            out_kind <= KIND_ACK;
            out_metric <= '0;
            if (off_r[sess]) begin
              out_offline_seen <= 1'b1;
              out_offline_elapsed_ms <= cmd_r.now - off_time_r[sess];
              off_r[sess] <= 1'b0;
            end
            if (exc_r[sess]) begin
              out_excursion_seen <= 1'b1;
              out_excursion_elapsed_ms <= cmd_r.now - exc_time_r[sess];
              if (am_ok && chk_valid_r && chk_avg_r <= threshold)
                exc_r[sess] <= 1'b0;
              else
                out_excursion_kept <= 1'b1;
            end
          end
          OP_HISTORY: begin
            out_kind <= KIND_EMPTY;
            hidx_r   <= hstart;
            hleft_r  <= fill_now;
            hpend_r  <= 1'b0;
          end
          default: out_valid <= 1'b0;
        endcase
      end
      if (state_r == ST_ALRM) begin
        out_valid <= 1'b1;
        out_kind  <= KIND_EXCURSION;
        out_value <= new_avg_r;
        out_last  <= 1'b1;
      end
      // History: address one cycle, data the next.
      if (state_r == ST_HIST) begin
        if (hpend_r) begin
          out_valid <= 1'b1;
          out_kind <= KIND_HIST;
          out_value <= $signed(ring_rd_r[31:0]);
          out_timestamp <= ring_rd_r[63:32];
          out_last <= (hleft_r == '0);
        end
        if (hleft_r != '0) begin
          hidx_r  <= (hidx_r == HW'(HISTORY_DEPTH-1)) ? '0 : hidx_r + 1'b1;
          hleft_r <= hleft_r - 1'b1;
          hpend_r <= 1'b1;
        end else begin
          hpend_r <= 1'b0;
        end
      end
    end
  end

  a_pop_idle: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |=> state_r == ST_EXEC) else $error("pop without exec");
  a_alarm_after_exec: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_ALRM |-> $past(state_r) == ST_EXEC) else $error("bad alarm entry");
  a_hist_out: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_kind == KIND_HIST) |-> $past(state_r) == ST_HIST)
    else $error("stray history result");
endmodule

/* rtl/sensor_channel_monitor_unit.sv */
// Top level of the sensor channel monitor.
// Usage: drive op, session, metric, value, timestamp and now on the in_ ports
// and raise start; a transaction is taken at an edge where start is high and
// busy is low. busy rises only while the two-entry command queue is full.
// Results appear on the out_ ports for one cycle, flagged by out_valid, and
// out_last marks the final result of a transaction. The receiver cannot stall.
// Configuration writes use cfg_valid/cfg_ready (always ready) with cfg_index
// 0 for the threshold and 1 for the alert metric; write only while idle.
// A transaction is queued, popped with registered channel reads, executed,
// and its result registered. The back end handles one transaction at a time;
// an excursion alert adds an alarm step after execute, and a history read of
// N samples goes pop, execute, a step to prime the registered read port of
// the sample ring, then one sample per cycle. Reset clears all control state
// and counts; memories need no clearing. The front drops out-of-range
// sessions, and out-of-range metrics on record or history, with no result.
module sensor_channel_monitor_unit #(
  parameter int SESSIONS      = 16,
  parameter int METRICS       = 4,
  parameter int HISTORY_DEPTH = 16
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         start,
  output logic         busy,
  input  logic [1:0]   in_op,
  input  logic [3:0]   in_session,
  input  logic [1:0]   in_metric,
  input  logic signed [31:0] in_value_milli,
  input  logic [31:0]  in_timestamp_ms,
  input  logic [31:0]  in_now_ms,
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [1:0]   cfg_index,
  input  logic [31:0]  cfg_data,
  output logic         out_valid,
  output logic [2:0]   out_kind,
  output logic [3:0]   out_session,
  output logic [1:0]   out_metric,
  output logic signed [31:0] out_value,
  output logic [31:0]  out_timestamp,
  output logic         out_offline_seen,
  output logic [31:0]  out_offline_elapsed_ms,
  output logic         out_excursion_seen,
  output logic [31:0]  out_excursion_elapsed_ms,
  output logic         out_excursion_kept,
  output logic         out_last
);
  import scm_pkg::*;

  cmd_t in_cmd, q_cmd;
  logic q_valid, q_pop;
  logic signed [31:0] thr_r;
  logic [1:0] am_r;

  assign in_cmd = '{op: op_t'(in_op), session: in_session, metric: in_metric,
                    value: in_value_milli, timestamp: in_timestamp_ms, now: in_now_ms};
  assign cfg_ready = 1'b1;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r <= THRESHOLD_RESET;
      am_r  <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_THRESHOLD: thr_r <= $signed(cfg_data);
        CFG_METRIC:    am_r  <= cfg_data[1:0];
        default:       ;
      endcase
    end
  end

  scm_front #(.SESSIONS(SESSIONS), .METRICS(METRICS), .QDEPTH(2)) u_front (
    .clk, .rst_n, .start, .busy, .in_cmd, .q_valid, .q_cmd, .q_pop
  );

  scm_back #(.SESSIONS(SESSIONS), .METRICS(METRICS), .HISTORY_DEPTH(HISTORY_DEPTH)) u_back (
    .clk, .rst_n, .q_valid, .q_cmd, .q_pop, .threshold(thr_r), .alert_metric(am_r),
    .out_valid, .out_kind, .out_session, .out_metric, .out_value, .out_timestamp,
    .out_offline_seen, .out_offline_elapsed_ms, .out_excursion_seen,
    .out_excursion_elapsed_ms, .out_excursion_kept, .out_last
  );
endmodule
